// ===== rtl/mlpfe_pkg.sv =====
package mlpfe_pkg;

  localparam int MaxInputs     = 64;
  localparam int MaxLayerWidth = 32;
  localparam int MaxLayers     = 4;
  localparam int MaxOutputs    = 16;
  localparam int WeightDepth   = 8192;

  localparam int WAddrW   = $clog2(WeightDepth);
  localparam int ActDepth = MaxLayers * MaxLayerWidth;
  localparam int ActAddrW = $clog2(ActDepth);
  localparam int AccW     = 48;

  typedef enum logic [1:0] {
    CFG_INPUT_COUNT  = 2'd0,
    CFG_LAYER_WIDTH  = 2'd1,
    CFG_LAYER_COUNT  = 2'd2,
    CFG_OUTPUT_COUNT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MAC,
    ST_FINISH,
    ST_SIG,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_L0,
    PH_HID,
    PH_OUT
  } phase_t;

  // elaboration-time quotient by shift and subtract
  function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid table: entries generated with the same fixed-point recipe
  function automatic logic [15:0] sig_lookup(input logic [7:0] t);
    logic [63:0] q;
    logic [63:0] d;
    logic [63:0] s;
    int          x;
    int          ax;
    q  = 64'd1 << 32;
    x  = int'(t) - 128;
    ax = (x < 0) ? -x : x;
    for (int k = 0; k < 128; k++) begin
      if (k < ax) q = (q * 64'd4034748382) >> 32;
    end
    d = (64'd1 << 32) + q;
    if (x >= 0) s = const_udiv((64'd1 << 48) + (d >> 1), d);
    else        s = const_udiv((q << 16) + (d >> 1), d);
    sig_lookup = (s > 64'd65535) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [255:0][15:0] sig_table_build();
    logic [255:0][15:0] tbl;
    for (int t = 0; t < 256; t++) tbl[t] = sig_lookup(8'(t));
    return tbl;
  endfunction

  localparam logic [255:0][15:0] SigTable = sig_table_build();

endpackage

// ===== rtl/mlpfe_sig_rom.sv =====
module mlpfe_sig_rom (
  input  logic        clk,
  input  logic [7:0]  addr,
  output logic [15:0] data
);
  import mlpfe_pkg::*;

  always_ff @(posedge clk) begin
    data <= SigTable[addr];
  end
endmodule

// ===== rtl/mlp_forward_evaluator_unit.sv =====
// Multilayer perceptron evaluator. A write transfer (func 0) stores one Q4.12 weight.
// An evaluate transfer (func 1) runs one shared 17x16 multiply-accumulate unit, one
// weight per cycle from the weight memory, and per neuron then drains the pipeline,
// looks up the sigmoid and writes the activation, or for the output layer sets the
// result bit. The block is not ready while evaluating; a finished result waits in
// the result register until the previous one has been taken.
module mlp_forward_evaluator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [12:0] weight_index,
  input  logic signed [15:0] weight_value,
  input  logic [63:0] input_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] output_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mlpfe_pkg::*;

  logic [6:0] input_count;
  logic [5:0] layer_width;
  logic [2:0] layer_count;
  logic [4:0] output_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count  <= 7'd64;
      layer_width  <= 6'd32;
      layer_count  <= 3'd4;
      output_count <= 5'd16;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INPUT_COUNT:  input_count  <= cfg_data[6:0];
        CFG_LAYER_WIDTH:  layer_width  <= cfg_data[5:0];
        CFG_LAYER_COUNT:  layer_count  <= cfg_data[2:0];
        CFG_OUTPUT_COUNT: output_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [6:0] ni;
  logic [5:0] nw;
  logic [2:0] nl;
  logic [4:0] no;
  assign ni = (input_count == 0) ? 7'd1 : (input_count > 7'(MaxInputs)) ? 7'(MaxInputs)
            : input_count;
  assign nw = (layer_width == 0) ? 6'd1 : (layer_width > 6'(MaxLayerWidth))
            ? 6'(MaxLayerWidth) : layer_width;
  assign nl = (layer_count == 0) ? 3'd1 : (layer_count > 3'(MaxLayers)) ? 3'(MaxLayers)
            : layer_count;
  assign no = (output_count == 0) ? 5'd1 : (output_count > 5'(MaxOutputs))
            ? 5'(MaxOutputs) : output_count;

  logic [15:0] wmem [WeightDepth];
  logic [15:0] amem [ActDepth];

  state_t state, state_next;
  phase_t phase;
  logic [63:0] bits;
  logic [WAddrW-1:0] pos;
  logic [6:0] j;
  logic [5:0] n;
  logic [2:0] l;
  logic [15:0] res;
  logic signed [AccW-1:0] acc;
  logic [15:0] wq, aq;
  logic        bq;
  logic        pv;
  logic        pv2;
  logic signed [32:0] prod;
  logic [7:0] sidx;
  logic [15:0] sdat;

  mlpfe_sig_rom u_rom (.clk(clk), .addr(sidx), .data(sdat));

  logic [6:0] jlim;
  assign jlim = (phase == PH_L0) ? ni : {1'b0, nw};
  logic [5:0] nlim;
  assign nlim = (phase == PH_OUT) ? {1'b0, no} : nw;

  logic [ActAddrW-1:0] rd_a, wr_a;
  assign rd_a = ActAddrW'(l - 3'd1) * ActAddrW'(nw) + ActAddrW'(j);
  assign wr_a = ActAddrW'(l) * ActAddrW'(nw) + ActAddrW'(n);

  assign in_ready = (state == ST_IDLE);

  // weight and activation writes; pipeline: fetch weight/activation, then multiply, then accumulate
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && !func) wmem[weight_index] <= weight_value;
    wq <= wmem[pos];
    aq <= amem[rd_a];
    bq <= bits[6'(j)];
    if (state == ST_SIG && phase != PH_OUT) amem[wr_a] <= sdat;
  end

  always_ff @(posedge clk) begin
    prod <= (phase == PH_L0) ? (bq ? 33'(signed'(wq)) : 33'sd0)
          : $signed({1'b0, aq}) * $signed(wq);
  end

  logic signed [AccW-1:0] flo;
  always_comb begin
    flo = (phase == PH_L0) ? (acc >>> 8) : (acc >>> 24);
    if (flo < -128) sidx = 8'd0;
    else if (flo > 127) sidx = 8'd255;
    else sidx = 8'(flo + 128);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid && in_ready && func) state_next = ST_MAC;
      ST_MAC:    if (j == jlim) state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_SIG;
      ST_SIG: begin
        if (n + 6'd1 == nlim && phase == PH_OUT) state_next = ST_DONE;
        else state_next = ST_MAC;
      end
      ST_DONE:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= PH_L0;
      acc       <= '0;
      pv        <= 1'b0;
      pv2       <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      pv  <= (state == ST_MAC) && (j != jlim);
      pv2 <= pv;
      if (pv2) acc <= acc + AccW'(prod);
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready && func) begin
            bits <= input_bits; pos <= '0; j <= '0; n <= '0; l <= 3'd0;
            res <= '0; phase <= PH_L0; acc <= '0;
          end
        end
        ST_MAC: begin
          if (j != jlim) begin
            j <= j + 7'd1;
            pos <= pos + 1'b1;
          end
        end
        ST_SIG: begin
          if (phase == PH_OUT) begin
            res[4'(n)] <= (acc > 0);
          end
          acc <= '0;
          j <= '0;
          if (n + 6'd1 == nlim) begin
            n <= '0;
            if (phase != PH_OUT) begin
              l <= l + 3'd1;
              phase <= (l + 3'd1 == nl) ? PH_OUT : PH_HID;
            end
          end else begin
            n <= n + 6'd1;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            output_bits <= res;
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/mlpfe_checker.sv =====
module mlpfe_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic func,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] output_bits
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(output_bits))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func |=> !in_ready)
    else $error("ready during evaluate");
  a_nowr: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !func && !out_valid |=> !out_valid)
    else $error("write produced result");
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready && !(in_valid && func) |=> !$rose(out_valid))
    else $error("result without evaluate");
endmodule

bind mlp_forward_evaluator_unit mlpfe_checker u_chk (.*);

// ===== dv/mlp_forward_evaluator_unit_tb.sv =====
`timescale 1ns / 100ps

module mlp_forward_evaluator_unit_tb;
  import mlpfe_pkg::*;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;
  localparam int   STALL_LIMIT = 30000;
  localparam int   PRELOAD = 66;

  typedef struct {
    logic                func;
    logic [12:0]         idx;
    logic signed [15:0]  val;
    logic [63:0]         bits;
  } net_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic [12:0] weight_index = '0;
  logic signed [15:0] weight_value = '0;
  logic [63:0] input_bits = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] output_bits;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  net_item_t   pending_items[$];
  logic [15:0] expected_bits[$];
  int          errors = 0;
  int          tx_idle_pct = 34;
  int          rx_idle_pct = 59;
  int          rx_hold = 0;
  int          stall_cycles = 0;

  logic [15:0] weight_mirror[WeightDepth];
  logic [15:0] act_mirror[ActDepth];
  logic [15:0] sig_rom[256];
  int          reg_mirror[4];

  mlp_forward_evaluator_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .weight_index(weight_index), .weight_value(weight_value),
    .input_bits(input_bits),
    .out_valid(out_valid), .out_ready(out_ready), .output_bits(output_bits),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_reg(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [15:0] squash(longint sum, int shift);
    longint x;
    x = sum >>> shift;
    if (x < -128) x = -128;
    if (x > 127) x = 127;
    return sig_rom[x + 128];
  endfunction

  function automatic longint weight_at(int pos);
    return longint'($signed(weight_mirror[pos % WeightDepth]));
  endfunction

  function automatic logic [15:0] evaluate_net(logic [63:0] bits);
    int ni, nw, nl, no, pos;
    longint acc;
    logic [15:0] res;
    ni = clamp_reg(reg_mirror[CFG_INPUT_COUNT], 1, MaxInputs);
    nw = clamp_reg(reg_mirror[CFG_LAYER_WIDTH], 1, MaxLayerWidth);
    nl = clamp_reg(reg_mirror[CFG_LAYER_COUNT], 1, MaxLayers);
    no = clamp_reg(reg_mirror[CFG_OUTPUT_COUNT], 1, (MaxOutputs < 16) ? MaxOutputs : 16);
    pos = 0;
    res = '0;
    for (int n = 0; n < nw; n++) begin
      acc = 0;
      for (int j = 0; j < ni; j++) begin
        if (bits[j]) acc += weight_at(pos);
        pos++;
      end
      act_mirror[n] = squash(acc, 8);
    end
    for (int l = 1; l < nl; l++) begin
      for (int n = 0; n < nw; n++) begin
        acc = 0;
        for (int j = 0; j < nw; j++) begin
          acc += longint'(act_mirror[(l - 1) * nw + j]) * weight_at(pos);
          pos++;
        end
        act_mirror[l * nw + n] = squash(acc, 24);
      end
    end
    for (int n = 0; n < no; n++) begin
      acc = 0;
      for (int j = 0; j < nw; j++) begin
        acc += longint'(act_mirror[(nl - 1) * nw + j]) * weight_at(pos);
        pos++;
      end
      if (acc > 0) res[n] = 1'b1;
    end
    return res;
  endfunction

  // driver: advance the pending queue, mirror each accepted write, predict each accepted evaluate
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (func == FUNC_WRITE) weight_mirror[weight_index] = weight_value;
        else expected_bits.push_back(evaluate_net(input_bits));
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          net_item_t it;
          it = pending_items.pop_front();
          in_valid     <= 1'b1;
          func         <= it.func;
          weight_index <= it.idx;
          weight_value <= it.val;
          input_bits   <= it.bits;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: drive out_ready, compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bits.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, output_bits);
          errors++;
        end else begin
          logic [15:0] want;
          want = expected_bits.pop_front();
          if (want !== output_bits) begin
            $display("%0t: output_bits mismatch, expected %h, actual %h",
                     $time, want, output_bits);
            errors++;
          end
        end
      end
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold = rx_hold - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_INPUT_COUNT:  reg_mirror[idx] = value & 'h7F;
      CFG_LAYER_WIDTH:  reg_mirror[idx] = value & 'h3F;
      CFG_LAYER_COUNT:  reg_mirror[idx] = value & 'h7;
      default:          reg_mirror[idx] = value & 'h1F;
    endcase
  endtask

  task automatic set_shape(int ni, int nw, int nl, int no);
    write_reg(CFG_INPUT_COUNT, ni);
    write_reg(CFG_LAYER_WIDTH, nw);
    write_reg(CFG_LAYER_COUNT, nl);
    write_reg(CFG_OUTPUT_COUNT, no);
  endtask

  task automatic push_write(int idx, int val);
    net_item_t it;
    it.func = FUNC_WRITE;
    it.idx  = 13'(idx);
    it.val  = 16'(val);
    it.bits = {$urandom, $urandom};
    pending_items.push_back(it);
  endtask

  task automatic push_eval(logic [63:0] bits);
    net_item_t it;
    it.func = FUNC_EVAL;
    it.idx  = 13'($urandom);
    it.val  = 16'($urandom);
    it.bits = bits;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() > 0 || expected_bits.size() > 0 || in_valid);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    set_shape($urandom_range(1, 12), $urandom_range(1, 3), $urandom_range(1, 3),
              $urandom_range(1, 4));
    push_eval({$urandom, $urandom});
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 55) push_eval({$urandom, $urandom});
      else if ($urandom_range(1)) push_write($urandom_range(PRELOAD - 1), $urandom);
      else push_write($urandom_range(PRELOAD - 1), $urandom_range(4095) - 2048);
    end
    drain();
  endtask

  initial begin
    logic [63:0] q[129];
    logic [63:0] d, s, p;
    q[0] = 64'd1 << 32;
    for (int k = 1; k <= 128; k++) q[k] = (q[k - 1] * 64'd4034748382) >> 32;
    for (int k = 0; k < 256; k++) begin
      p = q[(k < 128) ? 128 - k : k - 128];
      d = (64'd1 << 32) + p;
      if (k >= 128) s = ((64'd1 << 48) + d / 2) / d;
      else          s = ((p << 16) + d / 2) / d;
      sig_rom[k] = (s > 64'd65535) ? 16'hFFFF : s[15:0];
    end
    reg_mirror[0] = 64; reg_mirror[1] = 32; reg_mirror[2] = 4; reg_mirror[3] = 16;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_shape(4, 2, 2, 3);
    for (int i = 0; i < PRELOAD; i++) push_write(i, $urandom_range(2047) - 1024);
    drain();

    push_eval('0);
    push_eval('1);
    push_eval(64'hAAAA_AAAA_AAAA_AAAA);
    push_write(0, -32768);
    push_write(WeightDepth - 1, 32767);
    push_write(1, 32767);
    push_eval(64'h5555_5555_5555_5555);
    drain();
    set_shape(0, 0, 0, 0);
    push_eval('1);
    push_eval(64'h1);
    push_eval('0);
    drain();
    set_shape(127, 1, 1, 1);
    push_eval({$urandom, $urandom});
    drain();
    set_shape(1, 1, 7, 31);
    push_eval('1);
    drain();
    set_shape(1, 1, 1, 1);
    push_eval(64'h1);
    push_eval(64'hFFFF_FFFF_FFFF_FFFE);
    drain();

    random_phase(5);
    random_phase(5);
    tx_idle_pct = 59;
    rx_idle_pct = 34;
    random_phase(5);
    random_phase(5);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(negedge clk);
    rx_hold = 1000;
    random_phase(6);

    repeat (50) @(posedge clk);
    if (errors == 0 && expected_bits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
